[rtl/sfs_pkg.sv]
// Package for the sprite flipbook sequencer: widths, codes and register indexes.
package sfs_pkg;

  localparam int TILE_W   = 16;
  localparam int TIME_W   = 16;
  localparam int PERIOD_W = 32;
  localparam int TIMER_W  = 33;
  localparam int MODE_W   = 3;
  localparam int ACTION_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Playback modes
  typedef enum logic [MODE_W-1:0] {
    MODE_NONE      = 3'd0,
    MODE_ONCE_FWD  = 3'd1,
    MODE_ONCE_BACK = 3'd2,
    MODE_LOOP_FWD  = 3'd3,
    MODE_LOOP_BACK = 3'd4,
    MODE_PINGPONG  = 3'd5
  } mode_t;

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_PLAY    = 2'd1,
    ACT_ENABLE  = 2'd2,
    ACT_DISABLE = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TILE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_TILE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 3'd5;

endpackage

[rtl/sprite_flipbook_sequencer_unit.sv]
// Sprite flipbook sequencer: tile animation control with a bit-serial divider.
//
// Usage: each transfer on the in_ channel carries one action (tick, play,
// enable, disable) and an elapsed time used by ticks. Every item yields exactly
// one transfer on the out_ channel: the tile shown when the item arrived, its
// column and row in the sheet, and the visible, anim_finished and playing flags.
// The cfg_ channel writes the six registers; cfg_ready is always high. Mode,
// start, end and period take effect at the next play item; tile count and
// tiles per row are used live.
// The column and row come from a restoring divider that retires one quotient
// bit per cycle; the timer add and then the frame step run while it works.
// One item is in flight at a time: a new item is accepted only once the last
// result has moved to the output register.
// A stalled receiver holds the result in the output register; the next item is
// accepted meanwhile, and its result waits until the held one is taken.
// Reset (synchronous, rst_n low) returns the registers to their defaults,
// tile 0, mode none, sprite enabled, and leaves out_valid low.
module sprite_flipbook_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sfs_pkg::ACTION_W-1:0]       in_action,
  input  logic [sfs_pkg::TIME_W-1:0]         in_elapsed,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sfs_pkg::TILE_W-1:0]         out_shown_tile,
  output logic [sfs_pkg::TILE_W-1:0]         out_tile_column,
  output logic [sfs_pkg::TILE_W-1:0]         out_tile_row,
  output logic                               out_visible,
  output logic                               out_anim_finished,
  output logic                               out_playing,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TW = sfs_pkg::TILE_W;
  localparam int CW = $clog2(TW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control state
  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Configuration registers
  logic [sfs_pkg::MODE_W-1:0]    playback_mode_r, playback_mode_nxt;
  logic [TW-1:0]                 start_tile_r, start_tile_nxt;
  logic [TW-1:0]                 end_tile_r, end_tile_nxt;
  logic [sfs_pkg::PERIOD_W-1:0]  frame_period_r, frame_period_nxt;
  logic [TW-1:0]                 tile_count_r, tile_count_nxt;
  logic [TW-1:0]                 tiles_per_row_r, tiles_per_row_nxt;

  // Animation state
  logic [TW-1:0]                 current_tile_r, current_tile_nxt;
  logic [sfs_pkg::TIMER_W-1:0]   frame_timer_r, frame_timer_nxt;
  sfs_pkg::mode_t                active_mode_r, active_mode_nxt;
  logic                          going_back_r, going_back_nxt;
  logic                          sprite_en_r, sprite_en_nxt;
  logic                          done_armed_r, done_armed_nxt;
  logic [TW-1:0]                 lat_start_r, lat_start_nxt;
  logic [TW-1:0]                 lat_end_r, lat_end_nxt;
  logic [sfs_pkg::PERIOD_W-1:0]  lat_period_r, lat_period_nxt;

  // Item and divider working registers
  logic                          tick_go_r, tick_go_nxt;
  logic                          done_r, done_nxt;
  logic [sfs_pkg::TIME_W-1:0]    elapsed_r, elapsed_nxt;
  logic [TW-1:0]                 shown_r, shown_nxt;
  logic [TW-1:0]                 rem_r, rem_nxt;
  logic [TW-1:0]                 quo_r, quo_nxt;
  logic [TW-1:0]                 divisor_r, divisor_nxt;

  // Output payload registers
  logic [TW-1:0]                 o_shown_r, o_shown_nxt;
  logic [TW-1:0]                 o_col_r, o_col_nxt;
  logic [TW-1:0]                 o_row_r, o_row_nxt;
  logic                          o_vis_r, o_vis_nxt;
  logic                          o_done_r, o_done_nxt;
  logic                          o_play_r, o_play_nxt;

  // Datapath intermediates
  logic                          in_xfer;
  logic                          cfg_xfer;
  logic                          out_free;
  logic [TW:0]                   div_sh;
  logic [TW:0]                   div_diff;
  logic                          div_ge;
  logic [sfs_pkg::TIMER_W:0]     timer_sum;
  logic                          timer_hit;
  logic                          at_end;
  logic                          step_neg;
  logic [TW:0]                   step_val;
  logic [TW-1:0]                 step_tile;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_shown_tile     = o_shown_r;
  assign out_tile_column    = o_col_r;
  assign out_tile_row       = o_row_r;
  assign out_visible        = o_vis_r;
  assign out_anim_finished  = o_done_r;
  assign out_playing        = o_play_r;

  // Restoring divider step for both column and row: one quotient bit per cycle
  assign div_sh   = {rem_r, quo_r[TW-1]};
  assign div_ge   = (div_sh >= {1'b0, divisor_r});
  assign div_diff = div_sh - {1'b0, divisor_r};

  // Saturating timer accumulate and period compare
  assign timer_sum = {1'b0, frame_timer_r} + {{(sfs_pkg::TIMER_W + 1 - sfs_pkg::TIME_W){1'b0}},
                                              elapsed_r};
  assign timer_hit = (frame_timer_r >= {1'b0, lat_period_r});
  assign at_end    = (current_tile_r == lat_end_r);

  // Next tile by the active mode, before wrapping
  always_comb begin
    step_neg = 1'b0;
    step_val = {1'b0, current_tile_r};
    unique case (active_mode_r)
      sfs_pkg::MODE_ONCE_FWD: begin
        if (!at_end) step_val = {1'b0, current_tile_r} + 1'b1;
      end
      sfs_pkg::MODE_ONCE_BACK: begin
        if (!at_end) begin
          step_neg = (current_tile_r == '0);
          step_val = {1'b0, current_tile_r} - 1'b1;
        end
      end
      sfs_pkg::MODE_LOOP_FWD: begin
        if (at_end) step_val = {1'b0, lat_start_r};
        else        step_val = {1'b0, current_tile_r} + 1'b1;
      end
      sfs_pkg::MODE_LOOP_BACK: begin
        if (at_end) begin
          step_val = {1'b0, lat_start_r};
        end else begin
          step_neg = (current_tile_r == '0);
          step_val = {1'b0, current_tile_r} - 1'b1;
        end
      end
      sfs_pkg::MODE_PINGPONG: begin
        if (going_back_r) begin
          step_neg = (current_tile_r == '0);
          step_val = {1'b0, current_tile_r} - 1'b1;
        end else begin
          step_val = {1'b0, current_tile_r} + 1'b1;
        end
      end
      default: ;
    endcase
    // Wrap over the tile count
    if (step_neg)                               step_tile = tile_count_r - 1'b1;
    else if (step_val >= {1'b0, tile_count_r})  step_tile = '0;
    else                                        step_tile = step_val[TW-1:0];
  end

  // Sequencer and next-state logic
  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = out_valid_r;
    playback_mode_nxt = playback_mode_r;
    start_tile_nxt    = start_tile_r;
    end_tile_nxt      = end_tile_r;
    frame_period_nxt  = frame_period_r;
    tile_count_nxt    = tile_count_r;
    tiles_per_row_nxt = tiles_per_row_r;
    current_tile_nxt  = current_tile_r;
    frame_timer_nxt   = frame_timer_r;
    active_mode_nxt   = active_mode_r;
    going_back_nxt    = going_back_r;
    sprite_en_nxt     = sprite_en_r;
    done_armed_nxt    = done_armed_r;
    lat_start_nxt     = lat_start_r;
    lat_end_nxt       = lat_end_r;
    lat_period_nxt    = lat_period_r;
    tick_go_nxt       = tick_go_r;
    done_nxt          = done_r;
    elapsed_nxt       = elapsed_r;
    shown_nxt         = shown_r;
    rem_nxt           = rem_r;
    quo_nxt           = quo_r;
    divisor_nxt       = divisor_r;
    o_shown_nxt       = o_shown_r;
    o_col_nxt         = o_col_r;
    o_row_nxt         = o_row_r;
    o_vis_nxt         = o_vis_r;
    o_done_nxt        = o_done_r;
    o_play_nxt        = o_play_r;

    // Drop out_valid once the result is taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // Register writes
    if (cfg_xfer) begin
      unique case (cfg_index)
        sfs_pkg::REG_PLAYBACK_MODE: playback_mode_nxt = cfg_data[sfs_pkg::MODE_W-1:0];
        sfs_pkg::REG_START_TILE:    start_tile_nxt    = cfg_data[TW-1:0];
        sfs_pkg::REG_END_TILE:      end_tile_nxt      = cfg_data[TW-1:0];
        sfs_pkg::REG_FRAME_PERIOD:  frame_period_nxt  = cfg_data[sfs_pkg::PERIOD_W-1:0];
        sfs_pkg::REG_TILE_COUNT:    tile_count_nxt    = cfg_data[TW-1:0];
        sfs_pkg::REG_TILES_PER_ROW: tiles_per_row_nxt = cfg_data[TW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // Capture the shown tile and load the divider
          shown_nxt   = current_tile_r;
          quo_nxt     = current_tile_r;
          rem_nxt     = '0;
          divisor_nxt = tiles_per_row_r;
          elapsed_nxt = in_elapsed;
          tick_go_nxt = 1'b0;
          done_nxt    = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = ST_DIV;
          unique case (sfs_pkg::action_t'(in_action))
            sfs_pkg::ACT_TICK: begin
              if (sprite_en_r) begin
                tick_go_nxt = 1'b1;
                // Stop a once mode that sits on its end tile
                if ((active_mode_r == sfs_pkg::MODE_ONCE_FWD ||
                     active_mode_r == sfs_pkg::MODE_ONCE_BACK) && at_end) begin
                  active_mode_nxt = sfs_pkg::MODE_NONE;
                  if (done_armed_r) begin
                    done_nxt       = 1'b1;
                    done_armed_nxt = 1'b0;
                  end
                end
              end
            end
            sfs_pkg::ACT_PLAY: begin
              if (playback_mode_r <= sfs_pkg::MODE_PINGPONG)
                active_mode_nxt = sfs_pkg::mode_t'(playback_mode_r);
              else
                active_mode_nxt = sfs_pkg::MODE_NONE;
              lat_start_nxt    = start_tile_r;
              lat_end_nxt      = end_tile_r;
              lat_period_nxt   = frame_period_r;
              current_tile_nxt = start_tile_r;
              going_back_nxt   = 1'b0;
              frame_timer_nxt  = '0;
              done_armed_nxt   = 1'b1;
            end
            sfs_pkg::ACT_ENABLE:  sprite_en_nxt = 1'b1;
            sfs_pkg::ACT_DISABLE: sprite_en_nxt = 1'b0;
            default: ;
          endcase
        end
      end

      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[TW-1:0] : div_sh[TW-1:0];
        quo_nxt = {quo_r[TW-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        // Accumulate elapsed time on the first divider step
        if (cnt_r == CW'(0) && tick_go_r && active_mode_r != sfs_pkg::MODE_NONE) begin
          if (timer_sum[sfs_pkg::TIMER_W]) frame_timer_nxt = '1;
          else                             frame_timer_nxt = timer_sum[sfs_pkg::TIMER_W-1:0];
        end
        // Advance one frame on the second divider step
        if (cnt_r == CW'(1) && tick_go_r && active_mode_r != sfs_pkg::MODE_NONE &&
            timer_hit) begin
          frame_timer_nxt  = frame_timer_r - {1'b0, lat_period_r};
          current_tile_nxt = step_tile;
          if (active_mode_r == sfs_pkg::MODE_PINGPONG &&
              (step_tile == lat_start_r || step_tile == lat_end_r))
            going_back_nxt = !going_back_r;
        end
        if (cnt_r == CW'(TW - 1)) state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          o_shown_nxt   = shown_r;
          o_col_nxt     = rem_r;
          o_row_nxt     = quo_r;
          o_vis_nxt     = tick_go_r;
          o_done_nxt    = done_r;
          o_play_nxt    = (active_mode_r != sfs_pkg::MODE_NONE);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      playback_mode_r <= sfs_pkg::MODE_NONE;
      start_tile_r    <= '0;
      end_tile_r      <= '0;
      frame_period_r  <= '0;
      tile_count_r    <= TW'(1);
      tiles_per_row_r <= TW'(1);
      current_tile_r  <= '0;
      frame_timer_r   <= '0;
      active_mode_r   <= sfs_pkg::MODE_NONE;
      going_back_r    <= 1'b0;
      sprite_en_r     <= 1'b1;
      done_armed_r    <= 1'b0;
      lat_start_r     <= '0;
      lat_end_r       <= '0;
      lat_period_r    <= '0;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      playback_mode_r <= playback_mode_nxt;
      start_tile_r    <= start_tile_nxt;
      end_tile_r      <= end_tile_nxt;
      frame_period_r  <= frame_period_nxt;
      tile_count_r    <= tile_count_nxt;
      tiles_per_row_r <= tiles_per_row_nxt;
      current_tile_r  <= current_tile_nxt;
      frame_timer_r   <= frame_timer_nxt;
      active_mode_r   <= active_mode_nxt;
      going_back_r    <= going_back_nxt;
      sprite_en_r     <= sprite_en_nxt;
      done_armed_r    <= done_armed_nxt;
      lat_start_r     <= lat_start_nxt;
      lat_end_r       <= lat_end_nxt;
      lat_period_r    <= lat_period_nxt;
      tick_go_r       <= tick_go_nxt;
      done_r          <= done_nxt;
      elapsed_r       <= elapsed_nxt;
      shown_r         <= shown_nxt;
      rem_r           <= rem_nxt;
      quo_r           <= quo_nxt;
      divisor_r       <= divisor_nxt;
      o_shown_r       <= o_shown_nxt;
      o_col_r         <= o_col_nxt;
      o_row_r         <= o_row_nxt;
      o_vis_r         <= o_vis_nxt;
      o_done_r        <= o_done_nxt;
      o_play_r        <= o_play_nxt;
    end
  end

endmodule
